@@ hdl/assert_macros.svh @@
// Assertion macros for the ARP cache modules, included by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checked at every rising clock edge, reset included.
`define ARPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ hdl/arpc_pkg.sv @@
// Types and constants shared by the ARP cache responder modules.
`timescale 1ns / 1ps

package arpc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_OUR_IP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUR_MAC = 2'd1;

   // Input functions.
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_PACKET = 1'b1;

   // Packet checks.
   localparam logic [15:0] MIN_PKT_LEN = 16'd28;
   localparam logic [15:0] HW_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4  = 16'h0800;
   localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

   // Result kinds.
   localparam logic [2:0] KIND_HIT     = 3'd0;
   localparam logic [2:0] KIND_MISS    = 3'd1;
   localparam logic [2:0] KIND_DROP    = 3'd2;
   localparam logic [2:0] KIND_CACHED  = 3'd3;
   localparam logic [2:0] KIND_REPLIED = 3'd4;

   // Transmitted opcodes.
   localparam logic [1:0] TX_OP_NONE    = 2'd0;
   localparam logic [1:0] TX_OP_REQUEST = 2'd1;
   localparam logic [1:0] TX_OP_REPLY   = 2'd2;

   typedef struct packed {
      logic        func;
      logic [31:0] query_ip;
      logic [15:0] pkt_len;
      logic [15:0] hw_type;
      logic [15:0] proto_code;
      logic [15:0] arp_op;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [31:0] dst_ip;
   } arpc_req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [47:0] found_mac;
      logic        tx_valid;
      logic [1:0]  tx_opcode;
      logic        tx_broadcast;
      logic [47:0] tx_dest_mac;
      logic [47:0] tx_target_mac;
      logic [31:0] tx_target_ip;
   } arpc_rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } arpc_entry_type;

   localparam int ENTRY_W = $bits(arpc_entry_type);

   typedef struct packed {
      logic [31:0] our_ip;
   } arpc_cfg_type;

endpackage

@@ hdl/arpc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/arpc_seq.sv @@
// Sequencer that walks the cache one entry a cycle through a single compare unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpc_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  arpc_pkg::arpc_req_type                req_item,
   input  arpc_pkg::arpc_cfg_type                cfg,
   output logic                                  busy,
   output logic                                  rsp_valid,
   output arpc_pkg::arpc_rsp_type                rsp_item,
   output logic                                  ram_wr_en,
   output logic [arpc_pkg::IDX_W-1:0]            ram_wr_addr,
   output logic [arpc_pkg::ENTRY_W-1:0]          ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [arpc_pkg::IDX_W-1:0]            ram_rd_addr,
   input  logic [arpc_pkg::ENTRY_W-1:0]          ram_rd_data
);

   localparam int STATE_W = 1;
   localparam logic [STATE_W-1:0] ST_IDLE = 1'b0;
   localparam logic [STATE_W-1:0] ST_SCAN = 1'b1;

   logic [STATE_W-1:0]                state_ff, state_in;
   arpc_pkg::arpc_req_type            item_ff, item_in;
   logic [31:0]                       key_ff, key_in;
   logic [arpc_pkg::CNT_W-1:0]        issue_ff, issue_in;
   logic                              cmp_vld_ff, cmp_vld_in;
   logic [arpc_pkg::IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                              free_vld_ff, free_vld_in;
   logic [arpc_pkg::IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [arpc_pkg::ENTRIES-1:0]      valid_ff, valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   arpc_pkg::arpc_rsp_type            rsp_ff, rsp_in;

   arpc_pkg::arpc_entry_type          entry;
   arpc_pkg::arpc_entry_type          new_entry;
   logic                              cmp_hit;
   logic                              is_last;
   logic                              pkt_bad;
   logic                              do_reply;

   assign entry   = arpc_pkg::arpc_entry_type'(ram_rd_data);
   // The one shared comparator: the entry read last cycle against the key.
   assign cmp_hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (entry.ip == key_ff);
   assign is_last = (cmp_idx_ff == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1));

   assign pkt_bad = (req_item.pkt_len < arpc_pkg::MIN_PKT_LEN)
                    || (req_item.hw_type != arpc_pkg::HW_ETHERNET)
                    || (req_item.proto_code != arpc_pkg::PROTO_IPV4);

   assign do_reply = (item_ff.arp_op == arpc_pkg::ARP_OP_REQUEST)
                     && (item_ff.dst_ip == cfg.our_ip);

   assign new_entry.ip  = key_ff;
   assign new_entry.mac = item_ff.src_mac;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      key_in       = key_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[arpc_pkg::IDX_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff;
      ram_wr_data  = new_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = req_item;
               key_in      = (req_item.func == arpc_pkg::FUNC_PACKET) ?
                             req_item.src_ip : req_item.query_ip;
               issue_in    = '0;
               free_vld_in = 1'b0;
               if ((req_item.func == arpc_pkg::FUNC_PACKET) && pkt_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.result_kind = arpc_pkg::KIND_DROP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < arpc_pkg::CNT_W'(arpc_pkg::ENTRIES)) begin
               ram_rd_en  = 1'b1;
               issue_in   = issue_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[arpc_pkg::IDX_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (!valid_ff[cmp_idx_ff] && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_hit || is_last) begin
                  state_in     = ST_IDLE;
                  cmp_vld_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (item_ff.func == arpc_pkg::FUNC_LOOKUP) begin
                     if (cmp_hit) begin
                        rsp_in.result_kind = arpc_pkg::KIND_HIT;
                        rsp_in.found_mac   = entry.mac;
                     end else begin
                        rsp_in.result_kind  = arpc_pkg::KIND_MISS;
                        rsp_in.tx_valid     = 1'b1;
                        rsp_in.tx_opcode    = arpc_pkg::TX_OP_REQUEST;
                        rsp_in.tx_broadcast = 1'b1;
                        rsp_in.tx_target_ip = key_ff;
                     end
                  end else begin
                     ram_wr_en = 1'b1;
                     // Known sender updates its own entry; otherwise the
                     // first free entry, or entry zero when the table is full.
                     priority if (cmp_hit) begin
                        ram_wr_addr = cmp_idx_ff;
                     end else if (free_vld_ff) begin
                        ram_wr_addr = free_idx_ff;
                     end else if (!valid_ff[cmp_idx_ff]) begin
                        ram_wr_addr = cmp_idx_ff;
                     end else begin
                        ram_wr_addr = '0;
                     end
                     if (do_reply) begin
                        rsp_in.result_kind   = arpc_pkg::KIND_REPLIED;
                        rsp_in.tx_valid      = 1'b1;
                        rsp_in.tx_opcode     = arpc_pkg::TX_OP_REPLY;
                        rsp_in.tx_dest_mac   = item_ff.src_mac;
                        rsp_in.tx_target_mac = item_ff.src_mac;
                        rsp_in.tx_target_ip  = item_ff.src_ip;
                     end else begin
                        rsp_in.result_kind = arpc_pkg::KIND_CACHED;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         free_vld_ff  <= free_vld_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      key_ff      <= key_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ARPC_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (valid_ff == '0) && (state_ff == ST_IDLE) && !rsp_valid_ff)
   `ARPC_ASSERT(a_write_in_scan, clock, reset, ram_wr_en |-> (state_ff == ST_SCAN))
   `ARPC_ASSERT(a_write_marks_valid, clock, reset, ram_wr_en |=> valid_ff[$past(ram_wr_addr)])
   `ARPC_ASSERT(a_start_progresses, clock, reset,
      (start && (state_ff == ST_IDLE)) |=> ((state_ff == ST_SCAN) || rsp_valid_ff))
   `ARPC_ASSERT(a_compare_in_scan, clock, reset, cmp_vld_ff |-> (state_ff == ST_SCAN))

endmodule

@@ hdl/arp_cache_responder.sv @@
// Top level of the ARP cache responder: configuration registers, sequencer and entry RAM.
`timescale 1ns / 1ps

// Usage:
// A command is transferred at a rising edge where start is high and busy is low.
// req_item.func selects a cache lookup or a received ARP packet. Exactly one
// result follows each command on rsp_item, marked by rsp_valid for a single
// cycle; the receiver cannot stall it, so it must take the transfer then.
// A dropped packet (short, not Ethernet or not IPv4) has its result on the
// ports in the cycle straight after the command's transfer and never raises
// busy. Otherwise the entries are read one a cycle from the entry RAM and
// compared in a single comparator, in order from entry 0: the scan stops at
// the first hit or after a full pass over the 16 entries, and the compare
// result is registered onto the ports. busy is low again in the cycle the
// result is shown, so the next command may be transferred at the edge that
// ends it. No new command is taken before the last one's result is shown;
// the single RAM read port walking the table sets how long each one takes.
// Configuration is written through csr_wr_en, csr_index and csr_wdata while
// the block is idle: index 0 is our IP address, index 1 our MAC address,
// other indexes are ignored. The MAC address appears on no output, so it is
// accepted and discarded.
// Reset is synchronous and clears all valid marks and our IP address; busy is
// held high during reset.

module arp_cache_responder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  arpc_pkg::arpc_req_type              req_item,
   output logic                                rsp_valid,
   output arpc_pkg::arpc_rsp_type              rsp_item,
   input  logic                                csr_wr_en,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [31:0]                      our_ip_ff, our_ip_in;
   arpc_pkg::arpc_cfg_type           cfg;
   logic                             ram_wr_en;
   logic [arpc_pkg::IDX_W-1:0]       ram_wr_addr;
   logic [arpc_pkg::ENTRY_W-1:0]     ram_wr_data;
   logic                             ram_rd_en;
   logic [arpc_pkg::IDX_W-1:0]       ram_rd_addr;
   logic [arpc_pkg::ENTRY_W-1:0]     ram_rd_data;

   always_comb begin
      our_ip_in = our_ip_ff;
      if (csr_wr_en && (csr_index == arpc_pkg::CSR_OUR_IP)) begin
         our_ip_in = csr_wdata[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         our_ip_ff <= '0;
      end else begin
         our_ip_ff <= our_ip_in;
      end
   end

   assign cfg.our_ip = our_ip_ff;

   arpc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_item    (req_item),
      .cfg         (cfg),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   arpc_ram #(
      .WIDTH (arpc_pkg::ENTRY_W),
      .DEPTH (arpc_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ dv/arpc_checker.sv @@
// Checker for the ARP cache responder: predicts every answer and compares it field by field.
`timescale 1ns / 1ps

module arpc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  arpc_pkg::arpc_req_type          req_item,
   input  logic                            rsp_valid,
   input  arpc_pkg::arpc_rsp_type          rsp_item,
   input  logic                            csr_wr_en,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              answers_owed,
   output int                              mismatch_count
);
   import arpc_pkg::*;

   logic [31:0]  cache_ip [ENTRIES];
   logic [47:0]  cache_mac [ENTRIES];
   logic         cache_valid [ENTRIES];
   logic [31:0]  local_ip;
   arpc_rsp_type pending_answers [$];
   int           errors = 0;
   int           answer_number = 0;

   assign mismatch_count = errors;

   // Lowest valid entry holding ip, or -1.
   function automatic int find_slot(input logic [31:0] ip);
      int slot;
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (cache_valid[i] && cache_ip[i] == ip) begin
            slot = i;
         end
      end
      return slot;
   endfunction

   // Works out the answer to one command and applies its effect on the cache.
   function automatic arpc_rsp_type resolve_command(input arpc_req_type cmd);
      arpc_rsp_type ans;
      int           slot;
      ans = '0;
      if (cmd.func == FUNC_LOOKUP) begin
         slot = find_slot(cmd.query_ip);
         if (slot >= 0) begin
            ans.result_kind = KIND_HIT;
            ans.found_mac   = cache_mac[slot];
         end else begin
            ans.result_kind  = KIND_MISS;
            ans.tx_valid     = 1'b1;
            ans.tx_opcode    = TX_OP_REQUEST;
            ans.tx_broadcast = 1'b1;
            ans.tx_target_ip = cmd.query_ip;
         end
      end else if (cmd.pkt_len < MIN_PKT_LEN || cmd.hw_type != HW_ETHERNET ||
                   cmd.proto_code != PROTO_IPV4) begin
         ans.result_kind = KIND_DROP;
      end else begin
         slot = find_slot(cmd.src_ip);
         if (slot < 0) begin
            // First free entry; with the table full, entry 0 is overwritten.
            slot = 0;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
               if (!cache_valid[i]) begin
                  slot = i;
               end
            end
         end
         cache_ip[slot]    = cmd.src_ip;
         cache_mac[slot]   = cmd.src_mac;
         cache_valid[slot] = 1'b1;
         if (cmd.arp_op == ARP_OP_REQUEST && cmd.dst_ip == local_ip) begin
            ans.result_kind   = KIND_REPLIED;
            ans.tx_valid      = 1'b1;
            ans.tx_opcode     = TX_OP_REPLY;
            ans.tx_dest_mac   = cmd.src_mac;
            ans.tx_target_mac = cmd.src_mac;
            ans.tx_target_ip  = cmd.src_ip;
         end else begin
            ans.result_kind = KIND_CACHED;
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: answer %0d, %s: expected %h, got %h",
               $realtime, answer_number, what, want, got);
      errors++;
   endtask

   task automatic compare_answer(input arpc_rsp_type want, input arpc_rsp_type got);
      if (want.result_kind !== got.result_kind)
         report_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      if (want.found_mac !== got.found_mac)
         report_mismatch("found_mac", 64'(want.found_mac), 64'(got.found_mac));
      if (want.tx_valid !== got.tx_valid)
         report_mismatch("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
      if (want.tx_opcode !== got.tx_opcode)
         report_mismatch("tx_opcode", 64'(want.tx_opcode), 64'(got.tx_opcode));
      if (want.tx_broadcast !== got.tx_broadcast)
         report_mismatch("tx_broadcast", 64'(want.tx_broadcast), 64'(got.tx_broadcast));
      if (want.tx_dest_mac !== got.tx_dest_mac)
         report_mismatch("tx_dest_mac", 64'(want.tx_dest_mac), 64'(got.tx_dest_mac));
      if (want.tx_target_mac !== got.tx_target_mac)
         report_mismatch("tx_target_mac", 64'(want.tx_target_mac), 64'(got.tx_target_mac));
      if (want.tx_target_ip !== got.tx_target_ip)
         report_mismatch("tx_target_ip", 64'(want.tx_target_ip), 64'(got.tx_target_ip));
   endtask

   always @(posedge clock) begin : watch
      arpc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
         end
         local_ip  = '0;
         pending_answers.delete();
      end else begin
         // The answer to an older command may be transferred on the same edge as a new command.
         if (rsp_valid === 1'b1) begin
            answer_number++;
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected answer, result_kind", 64'(KIND_HIT),
                               64'(rsp_item.result_kind));
            end else begin
               want = pending_answers.pop_front();
               compare_answer(want, rsp_item);
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid", 64'(1'b0), 64'(rsp_valid));
         end
         // Our MAC address shows on no output, so only our IP address is tracked.
         if (csr_wr_en) begin
            if (csr_index == CSR_OUR_IP) begin
               local_ip = csr_wdata[31:0];
            end
         end
         if (start && busy === 1'b0) begin
            pending_answers.push_back(resolve_command(req_item));
         end
      end
      answers_owed <= pending_answers.size();
   end

endmodule

@@ dv/arp_cache_responder_test.sv @@
// Testbench top for the ARP cache responder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module arp_cache_responder_test;
   import arpc_pkg::*;

   localparam int              POOL_SIZE      = 24;
   localparam int              PHASE_ITEMS    = 530;
   localparam int              WATCHDOG_LIMIT = 4000;
   localparam int              SETTLE_CYCLES  = 40;
   localparam logic [15:0]     ARP_OP_REPLY   = 16'h0002;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   arpc_req_type          req_item;
   logic                  rsp_valid;
   arpc_rsp_type          rsp_item;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    answers_owed;
   int                    mismatch_count;

   logic [31:0] address_pool [POOL_SIZE];
   logic [31:0] phase_ip;

   arp_cache_responder dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   arpc_checker arp_watch (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .answers_owed   (answers_owed),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Ends the run when nothing at all is transferred for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic logic [47:0] random_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[47:0];
   endfunction

   // Mostly addresses from a small pool, so that hits, updates and a full table are common.
   function automatic logic [31:0] pick_address();
      if ($urandom_range(4) == 0) begin
         return $urandom;
      end
      return address_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic arpc_req_type make_packet(input logic [15:0] len, input logic [15:0] hw,
                                                input logic [15:0] proto, input logic [15:0] op,
                                                input logic [31:0] sip, input logic [47:0] smac,
                                                input logic [31:0] tip);
      arpc_req_type cmd;
      cmd.func       = FUNC_PACKET;
      cmd.query_ip   = $urandom;
      cmd.pkt_len    = len;
      cmd.hw_type    = hw;
      cmd.proto_code = proto;
      cmd.arp_op     = op;
      cmd.src_ip     = sip;
      cmd.src_mac    = smac;
      cmd.dst_ip     = tip;
      return cmd;
   endfunction

   // Packet fields of a lookup are filled with noise; the block must ignore them.
   function automatic arpc_req_type make_lookup(input logic [31:0] ip);
      arpc_req_type cmd;
      cmd = make_packet(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom, random_mac(), $urandom);
      cmd.func     = FUNC_LOOKUP;
      cmd.query_ip = ip;
      return cmd;
   endfunction

   function automatic arpc_req_type random_command();
      logic [15:0] len;
      logic [15:0] hw;
      logic [15:0] proto;
      logic [15:0] op;
      int          flaw;
      int          op_roll;
      if ($urandom_range(99) < 40) begin
         return make_lookup(pick_address());
      end
      // Fifteen packets in a hundred are broken in one way; the rest are well formed.
      flaw    = $urandom_range(99);
      op_roll = $urandom_range(9);
      len     = (flaw < 5) ? 16'($urandom_range(27)) : 16'($urandom_range(65535, 28));
      hw      = (flaw >= 5 && flaw < 10) ? 16'($urandom) : HW_ETHERNET;
      proto   = (flaw >= 10 && flaw < 15) ? 16'($urandom) : PROTO_IPV4;
      if (op_roll < 5) begin
         op = ARP_OP_REQUEST;
      end else if (op_roll < 8) begin
         op = ARP_OP_REPLY;
      end else begin
         op = 16'($urandom);
      end
      return make_packet(len, hw, proto, op, pick_address(), random_mac(),
                         ($urandom_range(1) == 0) ? phase_ip : pick_address());
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, start still high.
   task automatic issue_command(input arpc_req_type cmd);
      start    <= 1'b1;
      req_item <= cmd;
      while (busy !== 1'b0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (answers_owed != 0);
   endtask

   // Writes both registers and both unused indexes; the unused ones must be ignored.
   task automatic load_config(input logic [31:0] ip, input logic [47:0] mac);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_OUR_IP;
      csr_wdata <= {16'($urandom), ip};
      @(negedge clock);
      csr_index <= CSR_OUR_MAC;
      csr_wdata <= mac;
      @(negedge clock);
      csr_index <= CSR_SPARE_LOW;
      csr_wdata <= random_mac();
      @(negedge clock);
      csr_index <= CSR_SPARE_HIGH;
      csr_wdata <= random_mac();
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phase_ip = ip;
      @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct);
      repeat (PHASE_ITEMS) begin
         while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clock);
         end
         issue_command(random_command());
      end
      drain();
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      phase_ip  = '0;
      address_pool[0] = 32'h0000_0000;
      address_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) begin
         address_pool[i] = $urandom;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      load_config(32'hC0A8_0001, 48'h0200_0000_0001);
      // Misses on an empty table, then each reason for a drop.
      issue_command(make_lookup(32'h0000_0000));
      issue_command(make_lookup(32'hFFFF_FFFF));
      issue_command(make_packet(16'd27, HW_ETHERNET, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      issue_command(make_packet(16'd0, HW_ETHERNET, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      issue_command(make_packet(16'd28, 16'h0000, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      issue_command(make_packet(16'd28, 16'hFFFF, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      issue_command(make_packet(16'd28, HW_ETHERNET, 16'h0000, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      issue_command(make_packet(16'd28, HW_ETHERNET, 16'hFFFF, ARP_OP_REQUEST,
                                32'h0A00_0001, random_mac(), phase_ip));
      // Caching, hits, a reply to a request for our address, and other opcodes.
      issue_command(make_packet(16'd28, HW_ETHERNET, PROTO_IPV4, ARP_OP_REPLY,
                                32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000));
      issue_command(make_lookup(32'hFFFF_FFFF));
      issue_command(make_packet(16'hFFFF, HW_ETHERNET, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0000_0000, 48'h0000_0000_0000, phase_ip));
      issue_command(make_lookup(32'h0000_0000));
      issue_command(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, ARP_OP_REQUEST,
                                32'h0A00_0002, random_mac(), phase_ip ^ 32'h1));
      issue_command(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'h0000,
                                32'h0A00_0003, random_mac(), phase_ip));
      issue_command(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'hFFFF,
                                32'h0A00_0004, random_mac(), phase_ip));
      // A known address gets its MAC replaced in place.
      issue_command(make_packet(16'd28, HW_ETHERNET, PROTO_IPV4, ARP_OP_REPLY,
                                32'hFFFF_FFFF, 48'h0123_4567_89AB, 32'h0000_0000));
      issue_command(make_lookup(32'hFFFF_FFFF));
      issue_command(make_packet(16'd42, HW_ETHERNET, PROTO_IPV4, ARP_OP_REQUEST,
                                32'hFFFF_FFFF, 48'hFEDC_BA98_7654, phase_ip));
      issue_command(make_lookup(32'hFFFF_FFFF));
      issue_command(make_lookup($urandom));
      drain();

      load_config(32'h0000_0000, 48'h0000_0000_0000);
      run_phase(13);
      load_config(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      run_phase(57);
      load_config($urandom, random_mac());
      run_phase(0);

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
